/* design/rss_pkg.sv */
package rss_pkg;

   // Sample and accumulator geometry.
   localparam int SAMPLE_BITS = 16;
   localparam int VAL_BITS    = SAMPLE_BITS - 1;
   localparam int COUNT_BITS  = 16;
   localparam int MAX_TERMS   = 65535;
   localparam int SUM_BITS    = VAL_BITS + COUNT_BITS;
   localparam int SUMSQ_BITS  = 2 * VAL_BITS + COUNT_BITS;
   localparam int SQ_BITS     = 2 * SUM_BITS;
   localparam int OUT_BITS    = 15;

   // Shared divider: the square of the sum is the widest dividend.
   localparam int DVD_BITS     = SQ_BITS;
   localparam int DIV_CNT_BITS = $clog2(DVD_BITS + 1);

   // Square root over the variance.
   localparam int RAD_BITS  = SUMSQ_BITS + 1;
   localparam int ROOT_BITS = (SUMSQ_BITS + 1) / 2;
   localparam int SQRT_TOP  = 2 * ((SUMSQ_BITS - 1) / 2);

   typedef enum logic [1:0] {
      DIV_MEAN,
      DIV_SQUARE,
      DIV_VAR
   } div_sel_type;

   typedef struct packed {
      logic        accum;
      logic        square;
      logic        div_start;
      div_sel_type div_sel;
      logic        root_start;
      logic        load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic sample_neg;
      logic count_zero;
      logic count_lt2;
      logic div_done;
      logic root_done;
   } dp_status_type;

endpackage

/* design/rss_req_if.sv */
interface rss_req_if;
   import rss_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);

endinterface

/* design/rss_rsp_if.sv */
interface rss_rsp_if;
   import rss_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] term_count;
   logic [OUT_BITS-1:0]   minimum;
   logic [OUT_BITS-1:0]   maximum;
   logic [OUT_BITS-1:0]   mean_value;
   logic [OUT_BITS-1:0]   std_dev;
   logic                  std_valid;
   logic                  overflow_flag;

   modport source (output valid, output term_count, output minimum, output maximum,
                   output mean_value, output std_dev, output std_valid,
                   output overflow_flag, input ready);
   modport sink (input valid, input term_count, input minimum, input maximum,
                 input mean_value, input std_dev, input std_valid,
                 input overflow_flag, output ready);

endinterface

/* design/running_sample_statistics_core.sv */
// Running statistics over lists of signed Q8.8 samples. Every non-negative
// sample is a one-cycle transfer that updates the count, sum, sum of squares,
// minimum and maximum; samples past 65535 in one list are dropped and flagged.
// A negative sample closes the list: the block stops taking samples and runs
// the mean division, the sum-squared division and the variance division (all
// on one shared restoring divider) and then a square root. A list of one
// sample needs only the mean division, and an empty list none, before its
// result is loaded. The result sits in an output register, so sampling of
// the next list resumes while it waits to be taken.
module running_sample_statistics_core (
   input  logic       clock,
   input  logic       reset,
   rss_req_if.sink    req_bus,
   rss_rsp_if.source  rsp_bus
);
   import rss_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   rss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rss_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .sample        (req_bus.sample),
      .term_count    (rsp_bus.term_count),
      .minimum       (rsp_bus.minimum),
      .maximum       (rsp_bus.maximum),
      .mean_value    (rsp_bus.mean_value),
      .std_dev       (rsp_bus.std_dev),
      .std_valid     (rsp_bus.std_valid),
      .overflow_flag (rsp_bus.overflow_flag)
   );

endmodule

/* design/rss_divider.sv */
module rss_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rss_pkg::DVD_BITS-1:0]   dividend,
   input  logic [rss_pkg::COUNT_BITS-1:0] divisor,
   output logic                          done,
   output logic [rss_pkg::DVD_BITS-1:0]   quotient
);
   import rss_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] cnt_ff;
   logic [COUNT_BITS-1:0]   rem_ff;
   logic [COUNT_BITS-1:0]   rem_in;
   logic [COUNT_BITS-1:0]   dsr_ff;
   logic [DVD_BITS-1:0]     dq_ff;
   logic [DVD_BITS-1:0]     dq_in;
   logic [COUNT_BITS:0]     trial;
   logic [COUNT_BITS:0]     diff;
   logic                    ge;

   // Restoring division, one quotient bit per cycle. The dividend shifts out
   // at the top of dq_ff while quotient bits shift in at the bottom.
   always_comb begin
      trial  = {rem_ff, dq_ff[DVD_BITS-1]};
      ge     = (trial >= {1'b0, dsr_ff});
      diff   = trial - {1'b0, dsr_ff};
      rem_in = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      dq_in  = {dq_ff[DVD_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_BITS'(DVD_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= dq_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule

/* design/rss_sqrt.sv */
module rss_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rss_pkg::SUMSQ_BITS-1:0] radicand,
   output logic                          done,
   output logic [rss_pkg::ROOT_BITS-1:0]  root
);
   import rss_pkg::*;

   logic                  busy_ff;
   logic                  done_ff;
   logic [SUMSQ_BITS-1:0] rem_ff;
   logic [SUMSQ_BITS-1:0] rem_in;
   logic [RAD_BITS-1:0]   res_ff;
   logic [RAD_BITS-1:0]   res_in;
   logic [RAD_BITS-1:0]   bit_ff;
   logic [RAD_BITS-1:0]   bit_in;
   logic [RAD_BITS-1:0]   trial;
   logic [RAD_BITS-1:0]   diff;
   logic                  ge;

   // Digit-by-digit square root, one result bit per cycle.
   always_comb begin
      trial  = res_ff + bit_ff;
      ge     = ({1'b0, rem_ff} >= trial);
      diff   = {1'b0, rem_ff} - trial;
      rem_in = ge ? diff[SUMSQ_BITS-1:0] : rem_ff;
      res_in = ge ? ((res_ff >> 1) + bit_ff) : (res_ff >> 1);
      bit_in = bit_ff >> 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (bit_in == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= radicand;
         res_ff <= '0;
         bit_ff <= RAD_BITS'(1) << SQRT_TOP;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         res_ff <= res_in;
         bit_ff <= bit_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[ROOT_BITS-1:0];

endmodule

/* design/rss_datapath.sv */
module rss_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  rss_pkg::dp_cmd_type            cmd,
   output rss_pkg::dp_status_type         status,
   input  logic [rss_pkg::SAMPLE_BITS-1:0] sample,
   output logic [rss_pkg::COUNT_BITS-1:0]  term_count,
   output logic [rss_pkg::OUT_BITS-1:0]    minimum,
   output logic [rss_pkg::OUT_BITS-1:0]    maximum,
   output logic [rss_pkg::OUT_BITS-1:0]    mean_value,
   output logic [rss_pkg::OUT_BITS-1:0]    std_dev,
   output logic                           std_valid,
   output logic                           overflow_flag
);
   import rss_pkg::*;

   logic [COUNT_BITS-1:0] count_ff;
   logic [SUM_BITS-1:0]   sum_ff;
   logic [SUMSQ_BITS-1:0] sumsq_ff;
   logic [VAL_BITS-1:0]   min_ff;
   logic [VAL_BITS-1:0]   max_ff;
   logic                  ovf_ff;

   logic [SQ_BITS-1:0]    sq_ff;
   logic [VAL_BITS-1:0]   mean_ff;
   logic [SUMSQ_BITS-1:0] qsq_ff;
   logic [SUMSQ_BITS-1:0] var_ff;
   logic [ROOT_BITS-1:0]  sd_ff;

   logic [COUNT_BITS-1:0] out_count_ff;
   logic [OUT_BITS-1:0]   out_min_ff;
   logic [OUT_BITS-1:0]   out_max_ff;
   logic [OUT_BITS-1:0]   out_mean_ff;
   logic [OUT_BITS-1:0]   out_sd_ff;
   logic                  out_sd_valid_ff;
   logic                  out_ovf_ff;

   logic [VAL_BITS-1:0]   raw;
   logic [2*VAL_BITS-1:0] raw_sq;
   logic [SQ_BITS-1:0]    sum_sq;
   logic [SUMSQ_BITS-1:0] num;
   logic [DVD_BITS-1:0]   div_dividend;
   logic [COUNT_BITS-1:0] div_divisor;
   logic                  div_done;
   logic [DVD_BITS-1:0]   div_quotient;
   logic                  root_done;
   logic [ROOT_BITS-1:0]  root;
   logic                  count_zero;
   logic                  count_lt2;
   logic                  count_full;

   assign raw        = sample[VAL_BITS-1:0];
   assign raw_sq     = raw * raw;
   assign sum_sq     = sum_ff * sum_ff;
   assign count_zero = (count_ff == '0);
   assign count_lt2  = (count_ff < COUNT_BITS'(2));
   assign count_full = (count_ff >= COUNT_BITS'(MAX_TERMS));

   // The sum of squares is never below the square term, but clamp anyway.
   assign num = (sumsq_ff >= qsq_ff) ? (sumsq_ff - qsq_ff) : '0;

   always_comb begin
      case (cmd.div_sel)
         DIV_MEAN: begin
            div_dividend = DVD_BITS'(sum_ff);
            div_divisor  = count_ff;
         end
         DIV_SQUARE: begin
            div_dividend = DVD_BITS'(sq_ff);
            div_divisor  = count_ff;
         end
         DIV_VAR: begin
            div_dividend = DVD_BITS'(num);
            div_divisor  = count_ff - 1'b1;
         end
         default: begin
            div_dividend = '0;
            div_divisor  = count_ff;
         end
      endcase
   end

   rss_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   rss_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.root_start),
      .radicand (var_ff),
      .done     (root_done),
      .root     (root)
   );

   // Accumulators for the current list; they clear when its result is loaded.
   always_ff @(posedge clock) begin
      if (reset || cmd.load_out) begin
         count_ff <= '0;
         sum_ff   <= '0;
         sumsq_ff <= '0;
         min_ff   <= '0;
         max_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.accum) begin
         if (count_full) begin
            ovf_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + 1'b1;
            sum_ff   <= sum_ff + SUM_BITS'(raw);
            sumsq_ff <= sumsq_ff + SUMSQ_BITS'(raw_sq);
            if (count_zero || (raw < min_ff)) begin
               min_ff <= raw;
            end
            if (count_zero || (raw > max_ff)) begin
               max_ff <= raw;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.square) begin
         sq_ff <= sum_sq;
      end
      if (div_done) begin
         case (cmd.div_sel)
            DIV_MEAN:   mean_ff <= div_quotient[VAL_BITS-1:0];
            DIV_SQUARE: qsq_ff  <= div_quotient[SUMSQ_BITS-1:0];
            DIV_VAR:    var_ff  <= div_quotient[SUMSQ_BITS-1:0];
            default:    mean_ff <= mean_ff;
         endcase
      end
      if (root_done) begin
         sd_ff <= root;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_count_ff    <= count_ff;
         out_min_ff      <= OUT_BITS'(min_ff);
         out_max_ff      <= OUT_BITS'(max_ff);
         out_mean_ff     <= count_zero ? '0 : OUT_BITS'(mean_ff);
         out_sd_ff       <= count_lt2 ? '0 : OUT_BITS'(sd_ff);
         out_sd_valid_ff <= ~count_lt2;
         out_ovf_ff      <= ovf_ff;
      end
   end

   assign status.sample_neg = sample[SAMPLE_BITS-1];
   assign status.count_zero = count_zero;
   assign status.count_lt2  = count_lt2;
   assign status.div_done   = div_done;
   assign status.root_done  = root_done;

   assign term_count    = out_count_ff;
   assign minimum       = out_min_ff;
   assign maximum       = out_max_ff;
   assign mean_value    = out_mean_ff;
   assign std_dev       = out_sd_ff;
   assign std_valid     = out_sd_valid_ff;
   assign overflow_flag = out_ovf_ff;

endmodule

/* design/rss_ctrl.sv */
module rss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  rss_pkg::dp_status_type status,
   output rss_pkg::dp_cmd_type    cmd
);
   import rss_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_QSQ_GO,
      ST_QSQ_WAIT,
      ST_VAR_GO,
      ST_VAR_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_DELIVER
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      req_xfer;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd            = '0;
      cmd.div_sel    = DIV_MEAN;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (!status.sample_neg) begin
                  cmd.accum = 1'b1;
               end else if (status.count_zero) begin
                  state_in = ST_DELIVER;
               end else begin
                  state_in = ST_MEAN_GO;
               end
            end
         end
         ST_MEAN_GO: begin
            // The square of the sum is taken while the mean division runs.
            cmd.square    = 1'b1;
            cmd.div_start = 1'b1;
            state_in      = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (status.div_done) begin
               state_in = status.count_lt2 ? ST_DELIVER : ST_QSQ_GO;
            end
         end
         ST_QSQ_GO: begin
            cmd.div_sel   = DIV_SQUARE;
            cmd.div_start = 1'b1;
            state_in      = ST_QSQ_WAIT;
         end
         ST_QSQ_WAIT: begin
            cmd.div_sel = DIV_SQUARE;
            if (status.div_done) begin
               state_in = ST_VAR_GO;
            end
         end
         ST_VAR_GO: begin
            cmd.div_sel   = DIV_VAR;
            cmd.div_start = 1'b1;
            state_in      = ST_VAR_WAIT;
         end
         ST_VAR_WAIT: begin
            cmd.div_sel = DIV_VAR;
            if (status.div_done) begin
               state_in = ST_ROOT_GO;
            end
         end
         ST_ROOT_GO: begin
            cmd.root_start = 1'b1;
            state_in       = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            if (status.root_done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            // Wait until the output register is free or being emptied.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* verif/tb_running_sample_statistics_core.sv */
`timescale 1ns / 100ps

module tb_running_sample_statistics_core;
   import rss_pkg::*;

   localparam int          DIR_ROWS     = 24;
   localparam int unsigned RANDOM_ITEMS = 850;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          DRAIN_CYCLES = 400;

   typedef struct packed {
      logic [COUNT_BITS-1:0] term_count;
      logic [OUT_BITS-1:0]   minimum;
      logic [OUT_BITS-1:0]   maximum;
      logic [OUT_BITS-1:0]   mean_value;
      logic [OUT_BITS-1:0]   std_dev;
      logic                  std_valid;
      logic                  overflow_flag;
   } list_summary_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   typed;
      list_summary_type       summary;
   } stim_row_type;

   localparam list_summary_type NO_SUMMARY = '0;

   logic clock;
   logic reset;

   rss_req_if req_bus();
   rss_rsp_if rsp_bus();

   running_sample_statistics_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   int unsigned req_idle_pct  = 24;
   int unsigned rsp_stall_pct = 86;
   int unsigned mismatches    = 0;
   int unsigned cycle_count   = 0;

   list_summary_type pending_summaries [$];

   // Running state of the list being collected.
   bit [COUNT_BITS-1:0] n_terms   = '0;
   bit [63:0]           run_sum   = '0;
   bit [63:0]           run_sumsq = '0;
   bit [OUT_BITS-1:0]   run_min   = '0;
   bit [OUT_BITS-1:0]   run_max   = '0;
   bit                  dropped   = 1'b0;

   // Typed summaries are the cases that follow directly from the definition;
   // the others are left to the running predictor.
   stim_row_type dir_rows [0:DIR_ROWS-1] = '{
      {16'hFFFF, 1'b1, 16'd0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0},
      {16'h8000, 1'b1, 16'd0, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0},
      {16'h7FFF, 1'b0, NO_SUMMARY},
      {16'hFFFF, 1'b1, 16'd1, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd0, 1'b0, 1'b0},
      {16'h0000, 1'b0, NO_SUMMARY},
      {16'h8000, 1'b1, 16'd1, 15'd0, 15'd0, 15'd0, 15'd0, 1'b0, 1'b0},
      {16'h7FFF, 1'b0, NO_SUMMARY},
      {16'h0000, 1'b0, NO_SUMMARY},
      {16'hC3A5, 1'b0, NO_SUMMARY},
      {16'h0100, 1'b0, NO_SUMMARY},
      {16'h0100, 1'b0, NO_SUMMARY},
      {16'h0100, 1'b0, NO_SUMMARY},
      {16'hFFFE, 1'b1, 16'd3, 15'h0100, 15'h0100, 15'h0100, 15'd0, 1'b1, 1'b0},
      {16'h7FFF, 1'b0, NO_SUMMARY},
      {16'h7FFF, 1'b0, NO_SUMMARY},
      {16'h8001, 1'b1, 16'd2, 15'h7FFF, 15'h7FFF, 15'h7FFF, 15'd0, 1'b1, 1'b0},
      {16'h1234, 1'b0, NO_SUMMARY},
      {16'h0001, 1'b0, NO_SUMMARY},
      {16'h7FFE, 1'b0, NO_SUMMARY},
      {16'h4000, 1'b0, NO_SUMMARY},
      {16'hABCD, 1'b0, NO_SUMMARY},
      {16'h5555, 1'b0, NO_SUMMARY},
      {16'h2AAA, 1'b0, NO_SUMMARY},
      {16'hF0F0, 1'b0, NO_SUMMARY}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit [31:0] int_sqrt(input bit [63:0] radicand);
      bit [63:0] root;
      bit [63:0] trial;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      return root[31:0];
   endfunction

   // Folds one sample into the running list; a negative sample closes it.
   task automatic account_sample(input logic [SAMPLE_BITS-1:0] s, output bit closed,
                                 output list_summary_type summary);
      bit [63:0] magnitude;
      bit [63:0] square_term;
      bit [63:0] spread;
      closed    = 1'b0;
      summary   = '0;
      magnitude = {49'd0, s[VAL_BITS-1:0]};
      if (!s[SAMPLE_BITS-1]) begin
         if (n_terms >= MAX_TERMS) begin
            dropped = 1'b1;
         end else begin
            if (n_terms == 0 || s[VAL_BITS-1:0] < run_min) run_min = s[VAL_BITS-1:0];
            if (n_terms == 0 || s[VAL_BITS-1:0] > run_max) run_max = s[VAL_BITS-1:0];
            n_terms   = n_terms + 1'b1;
            run_sum   = run_sum + magnitude;
            run_sumsq = run_sumsq + magnitude * magnitude;
         end
      end else begin
         closed                = 1'b1;
         summary.term_count    = n_terms;
         summary.overflow_flag = dropped;
         if (n_terms != 0) begin
            summary.minimum    = run_min;
            summary.maximum    = run_max;
            summary.mean_value = OUT_BITS'(run_sum / n_terms);
            if (n_terms >= 2) begin
               square_term       = (run_sum * run_sum) / n_terms;
               spread            = (run_sumsq >= square_term) ? run_sumsq - square_term : '0;
               summary.std_dev   = OUT_BITS'(int_sqrt(spread / (n_terms - 1)));
               summary.std_valid = 1'b1;
            end
         end
         n_terms   = '0;
         run_sum   = '0;
         run_sumsq = '0;
         run_min   = '0;
         run_max   = '0;
         dropped   = 1'b0;
      end
   endtask

   // Offers one sample and returns at the edge where the transfer happens.
   task automatic offer_sample(input logic [SAMPLE_BITS-1:0] s, input logic typed,
                               input list_summary_type typed_summary);
      bit               closed;
      list_summary_type predicted;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.sample <= s;
      do @(posedge clock); while (!req_bus.ready);
      account_sample(s, closed, predicted);
      if (closed) pending_summaries.push_back(typed ? typed_summary : predicted);
   endtask

   task automatic check_field(input string label, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_bus.ready <= !reset && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      list_summary_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_summaries.size() == 0) begin
            mismatches++;
            $display("%0t ns: result transfer with nothing expected, count %0d",
                     $time, rsp_bus.term_count);
         end else begin
            want = pending_summaries.pop_front();
            check_field("term_count", want.term_count, rsp_bus.term_count);
            check_field("minimum", 16'(want.minimum), 16'(rsp_bus.minimum));
            check_field("maximum", 16'(want.maximum), 16'(rsp_bus.maximum));
            check_field("mean_value", 16'(want.mean_value), 16'(rsp_bus.mean_value));
            check_field("std_dev", 16'(want.std_dev), 16'(rsp_bus.std_dev));
            check_field("std_valid", 16'(want.std_valid), 16'(rsp_bus.std_valid));
            check_field("overflow_flag", 16'(want.overflow_flag),
                        16'(rsp_bus.overflow_flag));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int unsigned            items_sent;
      int unsigned            list_len;
      int unsigned            style;
      int unsigned            anchor;
      int unsigned            pick;
      logic [SAMPLE_BITS-1:0] value;

      reset          = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.sample = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         offer_sample(dir_rows[i].sample, dir_rows[i].typed, dir_rows[i].summary);

      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         if (items_sent < RANDOM_ITEMS / 3) begin
            req_idle_pct  = 24;
            rsp_stall_pct = 86;
         end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct  = 86;
            rsp_stall_pct = 24;
         end else begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end

         if ($urandom_range(99) < 8) begin
            offer_sample(SAMPLE_BITS'($urandom_range(0, 65535)), 1'b0, NO_SUMMARY);
            items_sent++;
         end else begin
            pick = $urandom_range(99);
            if (pick < 12)      list_len = 0;
            else if (pick < 24) list_len = 1;
            else if (pick < 34) list_len = 2;
            else                list_len = $urandom_range(3, 20);
            style  = $urandom_range(3);
            anchor = $urandom_range(0, 32760);
            for (int k = 0; k < list_len; k++) begin
               case (style)
                  0: value = {1'b0, VAL_BITS'($urandom_range(0, 32767))};
                  1: value = $urandom_range(1) ? 16'h7FFF : 16'h0000;
                  2: value = {1'b0, VAL_BITS'(anchor + $urandom_range(0, 7))};
                  default: value = {1'b0, VAL_BITS'($urandom_range(0, 255))};
               endcase
               offer_sample(value, 1'b0, NO_SUMMARY);
               items_sent++;
            end
            offer_sample(SAMPLE_BITS'($urandom_range(32768, 65535)), 1'b0, NO_SUMMARY);
            items_sent++;
         end
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_summaries.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
